// ----- design/btgr_pkg.sv -----
// ----------------------------------------------------------------------------
// btgr_pkg: shared types and constants of the bitmap text glyph renderer
// Request structs, command and operation codes, configuration defaults and
// the sizes of the internal queues.
// ----------------------------------------------------------------------------
package btgr_pkg;

    localparam int STORE_BYTES_DEF      = 32768;
    localparam int MAX_GLYPH_WIDTH_DEF  = 32;
    localparam int MAX_GLYPH_HEIGHT_DEF = 32;

    // Widest store address over the allowed store sizes.
    localparam int STORE_ADDR_W = 16;
    localparam int MASK_W       = 32;
    localparam int BANK_COUNT   = MASK_W / 8;
    localparam int BANK_SEL_W   = $clog2(BANK_COUNT);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int OUT_QUEUE_DEPTH = 4;
    localparam int OUT_COUNT_W     = $clog2(OUT_QUEUE_DEPTH + 1);

    localparam logic [5:0]  CFG_WIDTH_RST  = 6'd8;
    localparam logic [5:0]  CFG_HEIGHT_RST = 6'd16;
    localparam logic [7:0]  CFG_STRIDE_RST = 8'd16;
    localparam logic [14:0] CFG_BASE_RST   = 15'd32;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] NULL_CODE    = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GLYPH_WIDTH  = 3'd0,
        CFG_GLYPH_HEIGHT = 3'd1,
        CFG_GLYPH_STRIDE = 3'd2,
        CFG_GLYPH_BASE   = 3'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_DRAW   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_START   = 2'd1,
        OP_NEWLINE = 2'd2,
        OP_GLYPH   = 2'd3
    } t_op;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DRAW = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        ink_color;
        logic [7:0]         char_code;
        logic [14:0]        load_addr;
        logic [7:0]         load_byte;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [31:0]        row_mask;
        logic [31:0]        row_color;
        logic               last_row;
    } t_out_req;

    // Effective glyph geometry, width and height already saturated.
    typedef struct packed {
        logic [5:0]  width;
        logic [5:0]  height;
        logic [7:0]  stride;
        logic [14:0] base;
    } t_glyph_cfg;

    typedef struct packed {
        t_op                     op;
        logic [STORE_ADDR_W-1:0] addr;
        logic [7:0]              data_byte;
        logic [15:0]             pos_x;
        logic [15:0]             pos_y;
        logic [31:0]             color;
    } t_op_entry;

endpackage

// ----- design/btgr_fifo.sv -----
// ----------------------------------------------------------------------------
// btgr_fifo: small synchronous queue
// Register-based FIFO used between the front and back and on the result side.
// ----------------------------------------------------------------------------
module btgr_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  T                           i_data,
    input  logic                       i_pop,
    output T                           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- design/btgr_front.sv -----
// ----------------------------------------------------------------------------
// btgr_front: request decoder
// Accepts input requests, drops null and unused ones, and turns the rest into
// operations for the back end, including the glyph start address.
// ----------------------------------------------------------------------------
module btgr_front (
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  btgr_pkg::t_in_req    i_in_data,
    input  btgr_pkg::t_glyph_cfg i_cfg,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output btgr_pkg::t_op_entry  o_q_data
);

    import btgr_pkg::*;

    logic                    keep;
    logic [15:0]             glyph_prod;
    logic [STORE_ADDR_W:0]   glyph_sum;
    t_op_entry               entry;

    assign glyph_prod = 16'(i_in_data.char_code) * 16'(i_cfg.stride);
    assign glyph_sum  = (STORE_ADDR_W+1)'(i_cfg.base) + (STORE_ADDR_W+1)'(glyph_prod);

    always_comb begin
        keep            = 1'b0;
        entry.op        = OP_LOAD;
        entry.addr      = STORE_ADDR_W'(i_in_data.load_addr);
        entry.data_byte = i_in_data.load_byte;
        entry.pos_x     = i_in_data.pos_x;
        entry.pos_y     = i_in_data.pos_y;
        entry.color     = i_in_data.ink_color;
        unique case (t_command'(i_in_data.command))
            CMD_LOAD: begin
                keep = 1'b1;
            end
            CMD_START: begin
                keep     = 1'b1;
                entry.op = OP_START;
            end
            CMD_DRAW: begin
                if (i_in_data.char_code == NEWLINE_CODE) begin
                    keep     = 1'b1;
                    entry.op = OP_NEWLINE;
                end else if (i_in_data.char_code != NULL_CODE) begin
                    keep       = 1'b1;
                    entry.op   = OP_GLYPH;
                    entry.addr = glyph_sum[STORE_ADDR_W-1:0];
                end
            end
            CMD_UNUSED: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full && keep;
    assign o_q_data   = entry;

endmodule

// ----- design/btgr_back.sv -----
// ----------------------------------------------------------------------------
// btgr_back: glyph store and row engine
// Runs queued store loads, string starts and newlines; draws glyphs one row
// per cycle from a four-bank byte store while the result queue has room.
// ----------------------------------------------------------------------------
module btgr_back #(
    parameter int STORE_BYTES      = btgr_pkg::STORE_BYTES_DEF,
    parameter int MAX_GLYPH_HEIGHT = btgr_pkg::MAX_GLYPH_HEIGHT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  btgr_pkg::t_glyph_cfg                 i_cfg,
    input  logic                                 i_q_empty,
    input  btgr_pkg::t_op_entry                  i_q_data,
    output logic                                 o_q_pop,
    input  logic [btgr_pkg::OUT_COUNT_W-1:0]     i_out_count,
    output logic                                 o_out_push,
    output btgr_pkg::t_out_req                   o_out_data
);

    import btgr_pkg::*;

    localparam int AW         = $clog2(STORE_BYTES);
    localparam int BANK_DEPTH = STORE_BYTES / BANK_COUNT;
    localparam int BW         = AW - BANK_SEL_W;
    localparam int RW         = $clog2(MAX_GLYPH_HEIGHT);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [15:0]           r_origin_x;
    logic [15:0]           r_cursor_x;
    logic [15:0]           r_cursor_y;
    logic [31:0]           r_color;
    logic [AW-1:0]         r_raddr;
    logic [RW-1:0]         r_row;
    logic                  r_b_valid;
    logic [BANK_SEL_W-1:0] r_b_lo;
    logic [15:0]           r_b_x;
    logic [15:0]           r_b_y;
    logic                  r_b_last;
    logic [31:0]           r_b_color;

    logic                  q_pop;
    logic                  issue;
    logic                  mem_we;
    logic                  last_row_now;
    logic                  can_issue;
    logic [5:0]            width_up;
    logic [2:0]            row_bytes;
    logic [OUT_COUNT_W:0]  occupancy;
    logic [BW-1:0]         bank_addr [BANK_COUNT];
    logic [7:0]            rd_byte [BANK_COUNT];
    logic [MASK_W-1:0]     mask;

    assign width_up     = i_cfg.width + 6'd7;
    assign row_bytes    = width_up[5:3];
    assign last_row_now = (r_row == RW'(i_cfg.height - 6'd1));
    assign occupancy    = {1'b0, i_out_count} + (OUT_COUNT_W+1)'(r_b_valid);
    assign can_issue    = (occupancy < (OUT_COUNT_W+1)'(OUT_QUEUE_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && (i_q_data.op == OP_GLYPH)) begin
                    n_state = BK_DRAW;
                end
            end
            BK_DRAW: begin
                if (can_issue && last_row_now) begin
                    n_state = BK_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        q_pop  = 1'b0;
        issue  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                q_pop = !i_q_empty;
            end
            BK_DRAW: begin
                issue = can_issue;
            end
        endcase
        mem_we = q_pop && (i_q_data.op == OP_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_origin_x <= '0;
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_color    <= '0;
            r_b_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b_valid <= issue;
            if (q_pop) begin
                unique case (i_q_data.op)
                    OP_LOAD: begin
                    end
                    OP_START: begin
                        r_origin_x <= i_q_data.pos_x;
                        r_cursor_x <= i_q_data.pos_x;
                        r_cursor_y <= i_q_data.pos_y;
                        r_color    <= i_q_data.color;
                    end
                    OP_NEWLINE: begin
                        r_cursor_x <= r_origin_x;
                        r_cursor_y <= r_cursor_y + 16'(i_cfg.height);
                    end
                    OP_GLYPH: begin
                    end
                endcase
            end
            if (issue && last_row_now) begin
                r_cursor_x <= r_cursor_x + 16'(i_cfg.width);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop && (i_q_data.op == OP_GLYPH)) begin
            r_raddr <= i_q_data.addr[AW-1:0];
            r_row   <= '0;
        end else if (issue) begin
            r_raddr <= r_raddr + AW'(row_bytes);
            r_row   <= r_row + 1'b1;
        end
        if (issue) begin
            r_b_lo    <= r_raddr[BANK_SEL_W-1:0];
            r_b_x     <= r_cursor_x;
            r_b_y     <= r_cursor_y + 16'(r_row);
            r_b_last  <= last_row_now;
            r_b_color <= r_color;
        end
    end

    always_comb begin
        logic [BANK_SEL_W-1:0] offset;
        logic [AW-1:0]         byte_addr;
        for (int i = 0; i < BANK_COUNT; i++) begin
            offset       = BANK_SEL_W'(i) - r_raddr[BANK_SEL_W-1:0];
            byte_addr    = r_raddr + AW'(offset);
            bank_addr[i] = byte_addr[AW-1:BANK_SEL_W];
        end
    end

    for (genvar gi = 0; gi < BANK_COUNT; gi++) begin : g_bank
        logic [7:0] r_mem [BANK_DEPTH];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (mem_we && (i_q_data.addr[BANK_SEL_W-1:0] == BANK_SEL_W'(gi))) begin
                r_mem[i_q_data.addr[AW-1:BANK_SEL_W]] <= i_q_data.data_byte;
            end
            if (issue) begin
                r_rd <= r_mem[bank_addr[gi]];
            end
        end

        assign rd_byte[gi] = r_rd;
    end

    always_comb begin
        logic [BANK_SEL_W-1:0] sel;
        logic [7:0]            row_byte;
        for (int c = 0; c < MASK_W; c++) begin
            sel      = r_b_lo + BANK_SEL_W'(c / 8);
            row_byte = rd_byte[sel];
            mask[c]  = row_byte[7 - (c % 8)] && (6'(c) < i_cfg.width);
        end
    end

    assign o_q_pop               = q_pop;
    assign o_out_push            = r_b_valid;
    assign o_out_data.pixel_x    = r_b_x;
    assign o_out_data.pixel_y    = r_b_y;
    assign o_out_data.row_mask   = mask;
    assign o_out_data.row_color  = r_b_color;
    assign o_out_data.last_row   = r_b_last;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (i_out_count < OUT_COUNT_W'(OUT_QUEUE_DEPTH)))
        else $error("row pushed into a full result queue");

    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && last_row_now) |=> (r_state == BK_IDLE))
        else $error("glyph did not end after its last row");

    a_issue_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_b_valid)
        else $error("issued row read did not reach the assembly stage");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DRAW) |-> (r_row <= RW'(i_cfg.height - 6'd1)))
        else $error("row counter ran past the glyph height");

endmodule

// ----- design/bitmap_text_glyph_renderer_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_text_glyph_renderer_top: bitmap font text renderer
// Configuration registers, request decoder, operation queue, row engine and
// result queue.
// ----------------------------------------------------------------------------
// A glyph request passes the operation queue, the row engine's draw state with
// its bank read registers, and the result queue; load, start and newline
// requests are executed as the back end pops them. Glyph rows come one row per
// cycle from the four-bank store read while the result queue has room.
// Reset is synchronous and active low: it clears the queues, cursor, origin
// and color and restores the default geometry; the glyph store keeps its data.
module bitmap_text_glyph_renderer_top #(
    parameter int STORE_BYTES      = btgr_pkg::STORE_BYTES_DEF,
    parameter int MAX_GLYPH_WIDTH  = btgr_pkg::MAX_GLYPH_WIDTH_DEF,
    parameter int MAX_GLYPH_HEIGHT = btgr_pkg::MAX_GLYPH_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [btgr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [btgr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  btgr_pkg::t_in_req                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output btgr_pkg::t_out_req                o_out_data
);

    import btgr_pkg::*;

    logic [5:0]             r_glyph_width;
    logic [5:0]             r_glyph_height;
    logic [7:0]             r_glyph_stride;
    logic [14:0]            r_glyph_base;
    t_glyph_cfg             cfg;

    logic                   q_push;
    t_op_entry              q_wdata;
    logic                   q_pop;
    t_op_entry              q_rdata;
    logic                   q_empty;
    logic                   q_full;

    logic                   out_push;
    t_out_req               out_wdata;
    logic                   out_empty;
    logic                   out_full;
    logic [OUT_COUNT_W-1:0] out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width  <= CFG_WIDTH_RST;
            r_glyph_height <= CFG_HEIGHT_RST;
            r_glyph_stride <= CFG_STRIDE_RST;
            r_glyph_base   <= CFG_BASE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_data[5:0];
                CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[5:0];
                CFG_GLYPH_STRIDE: r_glyph_stride <= i_cfg_data[7:0];
                CFG_GLYPH_BASE:   r_glyph_base   <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_glyph_width == 6'd0) begin
            cfg.width = 6'd1;
        end else if (r_glyph_width > 6'(MAX_GLYPH_WIDTH)) begin
            cfg.width = 6'(MAX_GLYPH_WIDTH);
        end else begin
            cfg.width = r_glyph_width;
        end
        if (r_glyph_height == 6'd0) begin
            cfg.height = 6'd1;
        end else if (r_glyph_height > 6'(MAX_GLYPH_HEIGHT)) begin
            cfg.height = 6'(MAX_GLYPH_HEIGHT);
        end else begin
            cfg.height = r_glyph_height;
        end
        cfg.stride = r_glyph_stride;
        cfg.base   = r_glyph_base;
    end

    btgr_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    btgr_fifo #(
        .T     (t_op_entry),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count ()
    );

    btgr_back #(
        .STORE_BYTES      (STORE_BYTES),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_wdata)
    );

    btgr_fifo #(
        .T     (t_out_req),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_wdata),
        .i_pop   (!i_out_stall),
        .o_data  (o_out_data),
        .o_empty (out_empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    assign o_out_valid = !out_empty;

    a_out_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_full |-> o_out_valid)
        else $error("full result queue shows no valid result");

    a_cfg_geometry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg.width != 6'd0) && (cfg.height != 6'd0))
        else $error("saturated glyph geometry is zero");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_full && !q_pop) |=> o_in_stall)
        else $error("input taken while the operation queue stayed full");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bitmap text glyph renderer
// Loads glyph bytes, sets the string origin and draws characters under many
// glyph geometries. A predictor in the bench renders every glyph row that an
// accepted request causes. A monitor compares each accepted row, field by
// field, with the oldest predicted row. Both channels idle at random, and
// one phase stalls the result side long enough to back up the request side.
// ----------------------------------------------------------------------------
module testbench;
    import btgr_pkg::*;

    localparam int STORE_SIZE     = STORE_BYTES_DEF;
    localparam int MAX_W          = MAX_GLYPH_WIDTH_DEF;
    localparam int MAX_H          = MAX_GLYPH_HEIGHT_DEF;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 3;
    localparam int PHASE_ITEMS    = 10;
    localparam int REPORT_MAX     = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 3'd5;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    wire                    in_stall;
    t_in_req                in_data = '0;
    wire                    out_valid;
    logic                   out_stall = 1'b0;
    t_out_req               out_data;

    bitmap_text_glyph_renderer_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Register shadows, written only while the block is idle.
    logic [5:0]  reg_width  = CFG_WIDTH_RST;
    logic [5:0]  reg_height = CFG_HEIGHT_RST;
    logic [7:0]  reg_stride = CFG_STRIDE_RST;
    logic [14:0] reg_base   = CFG_BASE_RST;

    // Predicted renderer state.
    logic [7:0]  font_mem [STORE_SIZE];
    logic [15:0] origin_x = '0;
    logic [15:0] cur_x = '0;
    logic [15:0] cur_y = '0;
    logic [31:0] ink = '0;

    // Store bytes that the queued requests have already written.
    bit          font_written [STORE_SIZE];

    t_in_req     reqs_to_send [$];
    t_out_req    rows_due [$];

    int          in_gap_max = 0;
    int          out_gap_max = 0;
    bit          long_hold_phase = 1'b0;
    bit          long_hold_done = 1'b0;
    int          send_wait = 0;
    int          recv_wait = 0;
    int          hold_left = 0;
    int          err_count = 0;
    int          report_count = 0;
    int          idle_cycles = 0;
    t_out_req    want_row;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic render_glyph_rows(input t_in_req req);
        int unsigned w;
        int unsigned h;
        int unsigned row_bytes;
        int unsigned glyph_addr;
        int unsigned row;
        int unsigned col;
        logic [7:0]  rb;
        logic [31:0] mask;
        t_out_req    row_out;
        w = clamp_dim(reg_width, MAX_W);
        h = clamp_dim(reg_height, MAX_H);
        case (t_command'(req.command))
            CMD_LOAD: begin
                font_mem[req.load_addr % STORE_SIZE] = req.load_byte;
            end
            CMD_START: begin
                origin_x = req.pos_x;
                cur_x    = req.pos_x;
                cur_y    = req.pos_y;
                ink      = req.ink_color;
            end
            CMD_DRAW: begin
                if (req.char_code == NEWLINE_CODE) begin
                    cur_x = origin_x;
                    cur_y = cur_y + 16'(h);
                end else if (req.char_code != NULL_CODE) begin
                    row_bytes  = (w + 7) / 8;
                    glyph_addr = reg_base + req.char_code * reg_stride;
                    for (row = 0; row < h; row++) begin
                        mask = '0;
                        for (col = 0; col < w; col++) begin
                            rb = font_mem[(glyph_addr + row * row_bytes + col / 8) % STORE_SIZE];
                            if (rb[7 - (col % 8)]) mask[col] = 1'b1;
                        end
                        row_out.pixel_x   = cur_x;
                        row_out.pixel_y   = cur_y + 16'(row);
                        row_out.row_mask  = mask;
                        row_out.row_color = ink;
                        row_out.last_row  = (row == h - 1);
                        rows_due.push_back(row_out);
                    end
                    cur_x = cur_x + 16'(w);
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_in_req random_req();
        t_in_req r;
        r.command   = CMD_UNUSED;
        r.pos_x     = 16'($urandom);
        r.pos_y     = 16'($urandom);
        r.ink_color = $urandom;
        r.char_code = 8'($urandom);
        r.load_addr = 15'($urandom);
        r.load_byte = 8'($urandom);
        return r;
    endfunction

    task automatic push_load(input logic [14:0] addr, input logic [7:0] value);
        t_in_req req;
        req = random_req();
        req.command   = CMD_LOAD;
        req.load_addr = addr;
        req.load_byte = value;
        font_written[addr] = 1'b1;
        reqs_to_send.push_back(req);
    endtask

    task automatic push_start(input logic [15:0] x, input logic [15:0] y,
                              input logic [31:0] color);
        t_in_req req;
        req = random_req();
        req.command   = CMD_START;
        req.pos_x     = x;
        req.pos_y     = y;
        req.ink_color = color;
        reqs_to_send.push_back(req);
    endtask

    // Every byte the glyph will read is loaded first if nothing wrote it yet.
    task automatic push_draw(input logic [7:0] code);
        t_in_req     req;
        int unsigned glyph_bytes;
        int unsigned glyph_addr;
        int unsigned a;
        int unsigned k;
        glyph_bytes = clamp_dim(reg_height, MAX_H) * ((clamp_dim(reg_width, MAX_W) + 7) / 8);
        glyph_addr  = reg_base + code * reg_stride;
        if (code != NULL_CODE && code != NEWLINE_CODE) begin
            for (k = 0; k < glyph_bytes; k++) begin
                a = (glyph_addr + k) % STORE_SIZE;
                if (!font_written[a]) push_load(a[14:0], 8'($urandom));
            end
        end
        req = random_req();
        req.command   = CMD_DRAW;
        req.char_code = code;
        reqs_to_send.push_back(req);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_GLYPH_WIDTH:  reg_width  = value[5:0];
            CFG_GLYPH_HEIGHT: reg_height = value[5:0];
            CFG_GLYPH_STRIDE: reg_stride = value[7:0];
            CFG_GLYPH_BASE:   reg_base   = value[14:0];
            default: begin
            end
        endcase
    endtask

    task automatic wait_idle();
        while (reqs_to_send.size() != 0 || in_valid || rows_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Request driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_valid && !in_stall) render_glyph_rows(in_data);
            if (!in_valid || !in_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (reqs_to_send.size() > 0) begin
                    in_data   <= reqs_to_send.pop_front();
                    in_valid  <= 1'b1;
                    send_wait = $urandom_range(0, in_gap_max);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Row monitor and result-side stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (rows_due.size() == 0) begin
                    err_count++;
                    if (report_count < REPORT_MAX) begin
                        $display("unexpected row: x %0d y %0d mask %h color %h last %b",
                                 out_data.pixel_x, out_data.pixel_y, out_data.row_mask,
                                 out_data.row_color, out_data.last_row);
                    end
                    report_count++;
                end else begin
                    want_row = rows_due.pop_front();
                    if (out_data.pixel_x !== want_row.pixel_x ||
                        out_data.pixel_y !== want_row.pixel_y ||
                        out_data.row_mask !== want_row.row_mask ||
                        out_data.row_color !== want_row.row_color ||
                        out_data.last_row !== want_row.last_row) begin
                        err_count++;
                        if (report_count < REPORT_MAX) begin
                            $display({"row mismatch: x %0d/%0d y %0d/%0d mask %h/%h ",
                                      "color %h/%h last %b/%b (expected/actual)"},
                                     want_row.pixel_x, out_data.pixel_x,
                                     want_row.pixel_y, out_data.pixel_y,
                                     want_row.row_mask, out_data.row_mask,
                                     want_row.row_color, out_data.row_color,
                                     want_row.last_row, out_data.last_row);
                        end
                        report_count++;
                    end
                end
                recv_wait = $urandom_range(0, out_gap_max);
            end
            if (long_hold_phase && !long_hold_done && out_valid) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        logic [7:0]            code_set [2];
        logic [CFG_DATA_W-1:0] data;
        int unsigned           glyph_bytes;
        int unsigned           pick;
        int                    phase;
        int                    i;
        foreach (font_mem[k]) font_mem[k] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: draw before any start, wrap of cursor and rows.
        in_gap_max  = 6;
        out_gap_max = 6;
        push_draw(8'd1);
        push_draw(NULL_CODE);
        push_start(16'h7FF8, 16'h7FF8, 32'hFFFF_FFFF);
        push_draw(8'd2);
        push_draw(8'd1);
        push_draw(NEWLINE_CODE);
        push_draw(8'd2);
        push_start(16'h8000, 16'h8000, 32'h0000_0000);
        push_draw(8'd1);
        begin
            t_in_req req;
            req = random_req();
            req.command = CMD_UNUSED;
            reqs_to_send.push_back(req);
        end
        wait_idle();

        // Widest glyph, stride above the range, store address wrap.
        write_cfg(CFG_GLYPH_WIDTH, 15'd32);
        write_cfg(CFG_GLYPH_HEIGHT, 15'd2);
        write_cfg(CFG_GLYPH_STRIDE, 15'd255);
        write_cfg(CFG_GLYPH_BASE, 15'h7FFF);
        write_cfg(CFG_INDEX_SPARE, 15'h0001);
        push_start(16'h0010, 16'hFFF0, 32'hA5A5_5A5A);
        push_draw(8'd255);
        push_draw(8'd1);
        push_draw(NEWLINE_CODE);
        wait_idle();

        // Zero width and height count as one, zero stride shares one glyph.
        write_cfg(CFG_GLYPH_WIDTH, 15'd0);
        write_cfg(CFG_GLYPH_HEIGHT, 15'd0);
        write_cfg(CFG_GLYPH_STRIDE, 15'd0);
        write_cfg(CFG_GLYPH_BASE, 15'd0);
        push_start(16'hFFFF, 16'h7FFF, 32'h1234_5678);
        push_draw(8'd1);
        push_draw(8'd2);
        push_draw(8'd254);
        push_draw(NEWLINE_CODE);
        wait_idle();

        // Oversized width and height saturate; upper data bits are dropped.
        write_cfg(CFG_GLYPH_WIDTH, 15'h7FFF);
        write_cfg(CFG_GLYPH_HEIGHT, 15'd2);
        write_cfg(CFG_GLYPH_STRIDE, 15'd128);
        write_cfg(CFG_GLYPH_BASE, 15'd1);
        push_draw(8'd3);
        wait_idle();

        write_cfg(CFG_GLYPH_WIDTH, 15'd4);
        write_cfg(CFG_GLYPH_HEIGHT, 15'h7FE1);
        push_draw(8'd3);
        wait_idle();

        write_cfg(CFG_GLYPH_WIDTH, 15'd1);
        write_cfg(CFG_GLYPH_HEIGHT, 15'd1);
        write_cfg(CFG_GLYPH_STRIDE, 15'd1);
        push_start(16'h7FFF, 16'h0000, 32'h8000_0001);
        push_draw(8'd4);
        push_draw(8'd5);
        wait_idle();

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            data = 15'($urandom);
            pick = $urandom_range(0, 9);
            data[5:0] = (pick == 0) ? 6'd0 : (pick == 1) ? 6'($urandom_range(33, 63))
                                                         : 6'($urandom_range(1, 32));
            write_cfg(CFG_GLYPH_WIDTH, data);
            data = 15'($urandom);
            pick = $urandom_range(0, 9);
            data[5:0] = (pick == 0) ? 6'd0 : 6'($urandom_range(1, 6));
            if (phase == 2) data[5:0] = 6'd6;
            write_cfg(CFG_GLYPH_HEIGHT, data);
            write_cfg(CFG_GLYPH_STRIDE, 15'($urandom));
            write_cfg(CFG_GLYPH_BASE, 15'($urandom));
            if ($urandom_range(0, 1)) write_cfg(CFG_INDEX_SPARE, 15'($urandom));

            if (phase == 2) begin
                in_gap_max      = 0;
                out_gap_max     = 0;
                long_hold_phase = 1'b1;
            end else begin
                in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 6;
                out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            end
            foreach (code_set[k]) code_set[k] = 8'($urandom_range(1, 255));
            glyph_bytes = clamp_dim(reg_height, MAX_H) * ((clamp_dim(reg_width, MAX_W) + 7) / 8);

            push_start(16'($urandom), 16'($urandom), $urandom);
            if (phase == 2) push_draw(code_set[0]);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    push_start(16'($urandom), 16'($urandom), $urandom);
                end else if (pick < 68) begin
                    push_draw(code_set[$urandom_range(0, 1)]);
                end else if (pick < 76) begin
                    push_draw(NEWLINE_CODE);
                end else if (pick < 80) begin
                    push_draw(NULL_CODE);
                end else if (pick < 90) begin
                    push_load(15'($urandom), 8'($urandom));
                end else if (pick < 96) begin
                    push_load(15'((reg_base + code_set[$urandom_range(0, 1)] * reg_stride +
                                   $urandom_range(0, glyph_bytes - 1)) % STORE_SIZE),
                              8'($urandom));
                end else begin
                    t_in_req req;
                    req = random_req();
                    req.command = CMD_UNUSED;
                    reqs_to_send.push_back(req);
                end
            end
            wait_idle();
        end

        if (err_count == 0 && rows_due.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/btgr_pkg.sv
design/btgr_fifo.sv
design/btgr_front.sv
design/btgr_back.sv
design/bitmap_text_glyph_renderer_top.sv
dv/testbench.sv
